@@ rtl/lcdni_pkg.sv @@
// shared types, codes and constants for the lcd number to expander byte stream block
// no dependencies
`default_nettype none

package lcdni_pkg;

  localparam int unsigned MAX_CHARS = 5;

  typedef enum logic [2:0] {
    OP_CHAR   = 3'd0,
    OP_HEX8   = 3'd1,
    OP_HEX16  = 3'd2,
    OP_DEC8   = 3'd3,
    OP_DEC16  = 3'd4,
    OP_CURSOR = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_HOME   = 3'd7
  } op_e;

  localparam logic [7:0]  ASCII_ZERO    = 8'h30;
  localparam logic [7:0]  ASCII_ALPHA   = 8'h37;
  localparam logic [7:0]  CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0]  CMD_CLEAR     = 8'h01;
  localparam logic [7:0]  CMD_HOME      = 8'h02;
  // x / 10 == (x * 0xcccd) >> 19 for any 16-bit x
  localparam logic [15:0] DEC_RECIP     = 16'hCCCD;
  localparam int unsigned DEC_SHIFT     = 19;

  // six beats per character: high nibble (beats 0..2), low nibble (beats 3..5)
  localparam logic [2:0] BEAT_FIRST    = 3'd0;
  localparam logic [2:0] BEAT_E_HI     = 3'd1;
  localparam logic [2:0] BEAT_LO_START = 3'd3;
  localparam logic [2:0] BEAT_E_LO     = 3'd4;
  localparam logic [2:0] BEAT_LAST     = 3'd5;

  typedef struct packed {
    logic                            rs;
    logic [2:0]                      cnt;
    logic [MAX_CHARS-1:0][7:0]       chars;
  } msg_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d <= 4'd9) begin
      r = ASCII_ZERO + {4'h0, d};
    end else begin
      r = ASCII_ALPHA + {4'h0, d};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lcdni_format.sv @@
// command register and formatter: turns one command into up to five bytes for the display
// decimal digits come from a divide-by-ten step per cycle; depends on lcdni_pkg
`default_nettype none

module lcdni_format import lcdni_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  in_op_i,
  input  wire logic [15:0] in_value_i,
  input  wire logic        in_line_i,
  input  wire logic [5:0]  in_column_i,
  output logic             msg_valid_o,
  input  wire logic        msg_ready_i,
  output msg_t             msg_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  msg_t        msg_q, msg_d;
  logic [15:0] work_q, work_d;
  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] quot10;
  logic [15:0] rem;
  logic        accept;
  op_e         op;

  assign op     = op_e'(in_op_i);
  assign accept = in_valid_i && in_ready_o;

  assign prod   = {16'h0000, work_q} * {16'h0000, DEC_RECIP};
  assign quot   = {3'b000, prod[31:DEC_SHIFT]};
  assign quot10 = {quot[12:0], 3'b000} + {quot[14:0], 1'b0};
  assign rem    = work_q - quot10;

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_DONE) && msg_ready_i);
    msg_valid_o = (state_q == ST_DONE);
    msg_o       = msg_q;
  end

  always_comb begin
    state_d = state_q;
    msg_d   = msg_q;
    work_d  = work_q;
    if (accept) begin
      state_d   = ST_DONE;
      msg_d     = '0;
      msg_d.rs  = 1'b1;
      msg_d.cnt = 3'd1;
      case (op)
        OP_CHAR: begin
          msg_d.chars[0] = in_value_i[7:0];
        end
        OP_HEX8: begin
          msg_d.chars[0] = hex_digit(in_value_i[3:0]);
          msg_d.chars[1] = hex_digit(in_value_i[7:4]);
          msg_d.cnt      = (in_value_i[7:4] != 4'h0) ? 3'd2 : 3'd1;
        end
        OP_HEX16: begin
          msg_d.chars[0] = hex_digit(in_value_i[3:0]);
          msg_d.chars[1] = hex_digit(in_value_i[7:4]);
          msg_d.chars[2] = hex_digit(in_value_i[11:8]);
          msg_d.chars[3] = hex_digit(in_value_i[15:12]);
          if (in_value_i[15:12] != 4'h0) begin
            msg_d.cnt = 3'd4;
          end else if (in_value_i[11:8] != 4'h0) begin
            msg_d.cnt = 3'd3;
          end else if (in_value_i[7:4] != 4'h0) begin
            msg_d.cnt = 3'd2;
          end
        end
        OP_DEC8: begin
          state_d   = ST_DIV;
          msg_d.cnt = 3'd0;
          work_d    = {8'h00, in_value_i[7:0]};
        end
        OP_DEC16: begin
          state_d   = ST_DIV;
          msg_d.cnt = 3'd0;
          work_d    = in_value_i;
        end
        OP_CURSOR: begin
          msg_d.rs       = 1'b0;
          msg_d.chars[0] = CMD_SET_DDRAM | {1'b0, in_line_i, in_column_i};
        end
        OP_CLEAR: begin
          msg_d.rs       = 1'b0;
          msg_d.chars[0] = CMD_CLEAR;
        end
        default: begin
          msg_d.rs       = 1'b0;
          msg_d.chars[0] = CMD_HOME;
        end
      endcase
    end else begin
      case (state_q)
        ST_DIV: begin
          msg_d.chars[msg_q.cnt] = ASCII_ZERO + {4'h0, rem[3:0]};
          msg_d.cnt              = msg_q.cnt + 3'd1;
          work_d                 = quot;
          if (quot == 16'h0000) begin
            state_d = ST_DONE;
          end
        end
        ST_DONE: begin
          if (msg_ready_i) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q  <= msg_d;
    work_q <= work_d;
  end

`ifndef ASSERT_OFF
  a_div_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (msg_q.cnt < 3'd5))
    else $error("decimal conversion ran past five digits");

  a_done_has_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> ((msg_q.cnt != 3'd0) && (msg_q.cnt <= 3'd5)))
    else $error("finished message has no valid character count");

  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !in_ready_o)
    else $error("command accepted during decimal conversion");
`endif

endmodule

`default_nettype wire

@@ rtl/lcdni_emit.sv @@
// nibble sequencer and output register: six expander bytes per character, last one marked
// depends on lcdni_pkg
`default_nettype none

module lcdni_emit import lcdni_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       msg_valid_i,
  output logic            msg_ready_o,
  input  wire msg_t       msg_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic                      active_q, active_d;
  logic [2:0]                idx_q, idx_d;
  logic [2:0]                beat_q, beat_d;
  logic                      rs_q, rs_d;
  logic [MAX_CHARS-1:0][7:0] chars_q, chars_d;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic                      out_last_q, out_last_d;
  logic                      adv;
  logic                      final_beat;
  logic [7:0]                cur_char;
  logic [3:0]                nib;
  logic                      strobe;

  assign adv        = active_q && (!out_valid_q || out_ready_i);
  assign final_beat = (idx_q == 3'd0) && (beat_q == BEAT_LAST);
  assign cur_char   = chars_q[idx_q];
  assign nib        = (beat_q < BEAT_LO_START) ? cur_char[7:4] : cur_char[3:0];
  assign strobe     = (beat_q == BEAT_E_HI) || (beat_q == BEAT_E_LO);

  assign msg_ready_o = !active_q || (adv && final_beat);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    active_d    = active_q;
    idx_d       = idx_q;
    beat_d      = beat_q;
    rs_d        = rs_q;
    chars_d     = chars_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (adv) begin
      out_valid_d = 1'b1;
      // backlight always on, bit 1 unused
      out_byte_d  = {nib, 1'b1, strobe, 1'b0, rs_q};
      out_last_d  = final_beat;
      if (beat_q == BEAT_LAST) begin
        beat_d = BEAT_FIRST;
        if (idx_q == 3'd0) begin
          active_d = 1'b0;
        end else begin
          idx_d = idx_q - 3'd1;
        end
      end else begin
        beat_d = beat_q + 3'd1;
      end
    end
    if (msg_valid_i && msg_ready_o) begin
      active_d = 1'b1;
      idx_d    = msg_i.cnt - 3'd1;
      beat_d   = BEAT_FIRST;
      rs_d     = msg_i.rs;
      chars_d  = msg_i.chars;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
      beat_q      <= BEAT_FIRST;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      beat_q      <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q       <= rs_d;
    chars_q    <= chars_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

`ifndef ASSERT_OFF
  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((beat_q <= BEAT_LAST) && (idx_q < 3'd5)))
    else $error("character sequencer out of range");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && final_beat) |=> (out_valid_q && out_last_q))
    else $error("final byte of a command not marked last");

  a_no_last_midway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !final_beat) |=> !out_last_q)
    else $error("last marked before the final byte");
`endif

endmodule

`default_nettype wire

@@ rtl/lcd_number_to_i2c_nibble_stream.sv @@
// top level: character lcd command to i2c expander byte stream, 4-bit bus mode
// instantiates lcdni_format and lcdni_emit; depends on lcdni_pkg
//
// usage
//   s_axis carries one display command per transfer: tuser holds the operation
//   (char, hex8, hex16, dec8, dec16, cursor, clear, home), tdata the value,
//   cursor line and column. m_axis gives the expander bytes, one per transfer,
//   three per nibble with the enable strobe in the middle one; tlast marks the
//   final byte of each command.
//   a command gives 6 bytes per character: 6 for char, cursor, clear and home,
//   up to 24 for hex16 and up to 30 for dec16, one byte per cycle while the
//   receiver takes them. a command passes the formatter's message register and
//   the sequencer's character register before its first byte reaches the
//   output register; decimal commands first run the divide-by-ten step once
//   per printed digit (at most five). that conversion overlaps with the bytes
//   of the previous command, and the next command is taken while the current
//   one is still being sent, so consecutive commands stream with no gap.
//   a stall on m_axis holds the byte in the output register and freezes the
//   sequencer; the command input stops accepting once its buffer is full.
//   reset empties both stages; no bytes are pending after reset.
`default_nettype none

module lcd_number_to_i2c_nibble_stream import lcdni_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // value[15:0], line[16], column[22:17], zero[23]
  input  wire logic [2:0]  s_axis_tuser,  // operation[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // port_byte[7:0]
  output logic             m_axis_tlast
);

  logic msg_valid;
  logic msg_ready;
  msg_t msg;

  lcdni_format u_format (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_value_i  (s_axis_tdata[15:0]),
    .in_line_i   (s_axis_tdata[16]),
    .in_column_i (s_axis_tdata[22:17]),
    .msg_valid_o (msg_valid),
    .msg_ready_i (msg_ready),
    .msg_o       (msg)
  );

  lcdni_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .msg_valid_i (msg_valid),
    .msg_ready_o (msg_ready),
    .msg_i       (msg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ dv/tb_lcd_number_to_i2c_nibble_stream.sv @@
// testbench for lcd_number_to_i2c_nibble_stream: directed and random display commands,
// expected expander bytes predicted per command and checked against m_axis in order
// depends on lcdni_pkg and the lcd_number_to_i2c_nibble_stream rtl
`timescale 1ns / 1ps

module tb_lcd_number_to_i2c_nibble_stream;
  import lcdni_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 160;

  localparam logic [7:0] PORT_BL     = 8'h08;
  localparam logic [7:0] PORT_E      = 8'h04;
  localparam logic [7:0] LINE1_ADDR  = 8'h40;
  localparam int unsigned HEX8_DIGS  = 2;
  localparam int unsigned HEX16_DIGS = 4;
  localparam int unsigned DEC8_DIGS  = 3;
  localparam int unsigned DEC16_DIGS = 5;

  typedef struct packed {
    op_e         op;
    logic [15:0] value;
    logic        line;
    logic [5:0]  column;
  } lcd_cmd_t;

  typedef struct packed {
    logic [7:0] port_byte;
    logic       last;
  } lcd_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  lcd_cmd_t  pending_cmds[$];
  lcd_byte_t expected_bytes[$];
  lcd_cmd_t  offered_cmd;
  lcd_byte_t byte_want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_armed = 1'b0;
  logic        hold_served;
  int unsigned hold_left;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  lcd_number_to_i2c_nibble_stream i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one lcd byte as two nibbles, three expander bytes each, strobe in the middle
  function automatic void push_lcd_byte(input logic [7:0] c, input logic rs);
    logic [7:0] port;
    for (int n = 1; n >= 0; n--) begin
      port = {c[4*n +: 4], 4'h0} | PORT_BL | {7'd0, rs};
      expected_bytes.push_back('{port, 1'b0});
      expected_bytes.push_back('{port | PORT_E, 1'b0});
      expected_bytes.push_back('{port, 1'b0});
    end
  endfunction

  function automatic void expand_command(input lcd_cmd_t cmd);
    logic [3:0]  digs[DEC16_DIGS];
    logic [3:0]  d;
    logic [7:0]  addr;
    logic [15:0] v;
    int          ndig;
    bit          started;
    lcd_byte_t   tail;
    started = 1'b0;
    case (cmd.op)
      OP_CHAR: push_lcd_byte(cmd.value[7:0], 1'b1);
      OP_HEX8, OP_HEX16: begin
        ndig = (cmd.op == OP_HEX8) ? HEX8_DIGS : HEX16_DIGS;
        for (int i = ndig - 1; i >= 0; i--) begin
          d = cmd.value[4*i +: 4];
          if (d != 4'd0 || started || i == 0) begin
            started = 1'b1;
            push_lcd_byte((d <= 4'd9) ? ASCII_ZERO + {4'h0, d} : ASCII_ALPHA + {4'h0, d},
                          1'b1);
          end
        end
      end
      OP_DEC8, OP_DEC16: begin
        ndig = (cmd.op == OP_DEC8) ? DEC8_DIGS : DEC16_DIGS;
        v = (cmd.op == OP_DEC8) ? {8'd0, cmd.value[7:0]} : cmd.value;
        for (int i = 0; i < ndig; i++) begin
          digs[i] = 4'(v % 16'd10);
          v = v / 16'd10;
        end
        for (int i = ndig - 1; i >= 0; i--) begin
          if (digs[i] != 4'd0 || started || i == 0) begin
            started = 1'b1;
            push_lcd_byte(ASCII_ZERO + {4'h0, digs[i]}, 1'b1);
          end
        end
      end
      OP_CURSOR: begin
        addr = (cmd.line ? LINE1_ADDR : 8'd0) + {2'd0, cmd.column};
        push_lcd_byte(CMD_SET_DDRAM | addr, 1'b0);
      end
      OP_CLEAR: push_lcd_byte(CMD_CLEAR, 1'b0);
      default: push_lcd_byte(CMD_HOME, 1'b0);
    endcase
    tail = expected_bytes.pop_back();
    tail.last = 1'b1;
    expected_bytes.push_back(tail);
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expand_command(offered_cmd);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_cmd = pending_cmds.pop_front();
          s_axis_tdata  <= {1'b0, offered_cmd.column, offered_cmd.line, offered_cmd.value};
          s_axis_tuser  <= offered_cmd.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // byte monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_served = 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got %02h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          error_cnt++;
        end else begin
          byte_want = expected_bytes.pop_front();
          if (m_axis_tdata !== byte_want.port_byte) begin
            $display("%0t: port byte mismatch, expected %02h, got %02h",
                     $time, byte_want.port_byte, m_axis_tdata);
            error_cnt++;
          end
          if (m_axis_tlast !== byte_want.last) begin
            $display("%0t: last flag mismatch, expected %0b, got %0b",
                     $time, byte_want.last, m_axis_tlast);
            error_cnt++;
          end
        end
      end
      if (hold_armed && !hold_served) begin
        hold_served = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_cmd(input op_e op, input logic [15:0] value,
                           input logic line, input logic [5:0] column);
    pending_cmds.push_back('{op, value, line, column});
  endtask

  task automatic queue_random(input int unsigned count);
    lcd_cmd_t    cmd;
    logic [15:0] value;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(4))
        0: value = 16'($urandom_range(9));
        1: value = 16'($urandom_range(999));
        2: value = 16'hFFFF - 16'($urandom_range(15));
        default: value = 16'($urandom);
      endcase
      cmd.op     = op_e'(3'($urandom_range(7)));
      cmd.value  = value;
      cmd.line   = 1'($urandom_range(1));
      cmd.column = 6'($urandom_range(63));
      pending_cmds.push_back(cmd);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_cmds.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, every operation, leading zeros, unused inputs
    queue_cmd(OP_CHAR,   16'h0000, 1'b1, 6'd63);
    queue_cmd(OP_CHAR,   16'hABFF, 1'b0, 6'd0);
    queue_cmd(OP_CHAR,   16'h0080, 1'b1, 6'd21);
    queue_cmd(OP_HEX8,   16'h0000, 1'b0, 6'd0);
    queue_cmd(OP_HEX8,   16'hFF0A, 1'b1, 6'd63);
    queue_cmd(OP_HEX8,   16'h00FF, 1'b0, 6'd5);
    queue_cmd(OP_HEX16,  16'h0000, 1'b0, 6'd0);
    queue_cmd(OP_HEX16,  16'hFFFF, 1'b1, 6'd63);
    queue_cmd(OP_HEX16,  16'h00F0, 1'b0, 6'd9);
    queue_cmd(OP_HEX16,  16'h1000, 1'b1, 6'd1);
    queue_cmd(OP_DEC8,   16'h0000, 1'b0, 6'd0);
    queue_cmd(OP_DEC8,   16'hFFFF, 1'b1, 6'd63);
    queue_cmd(OP_DEC8,   16'h0009, 1'b0, 6'd2);
    queue_cmd(OP_DEC8,   16'h0064, 1'b1, 6'd3);
    queue_cmd(OP_DEC16,  16'd0,    1'b0, 6'd0);
    queue_cmd(OP_DEC16,  16'd65535, 1'b1, 6'd63);
    queue_cmd(OP_DEC16,  16'd10000, 1'b0, 6'd7);
    queue_cmd(OP_DEC16,  16'd99,   1'b1, 6'd4);
    queue_cmd(OP_CURSOR, 16'hFFFF, 1'b0, 6'd0);
    queue_cmd(OP_CURSOR, 16'h0000, 1'b1, 6'd63);
    queue_cmd(OP_CURSOR, 16'h5A5A, 1'b1, 6'd0);
    queue_cmd(OP_CLEAR,  16'hFFFF, 1'b1, 6'd63);
    queue_cmd(OP_HOME,   16'h0000, 1'b0, 6'd0);
    wait_drained();

    send_idle_pct = 32;
    recv_idle_pct = 88;
    queue_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 88;
    recv_idle_pct = 32;
    queue_random(PHASE_ITEMS);
    wait_drained();

    // receiver blocks for a long stretch while commands keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    queue_random(PHASE_ITEMS);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
